// ===== hw/rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY  = 256;
	localparam int ID_BITS   = 16;
	localparam int PRI_BITS  = 32;
	localparam int ADDR_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS  = ADDR_BITS + 1;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0]  slot_t;

	typedef struct packed {
		logic [ID_BITS-1:0]  id;
		logic [PRI_BITS-1:0] pri;
	} entry_t;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_FIND    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one write port and two read ports of the heap store
	typedef struct packed {
		logic   we;
		addr_t  waddr;
		entry_t wdata;
		addr_t  raddr_a;
		addr_t  raddr_b;
	} ram_req_t;

	// one-based slot to store address
	function automatic addr_t slot_to_addr(input slot_t s);
		slot_t d;
		d = s - slot_t'(1);
		return d[ADDR_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap slot store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram (
	input  logic               clk,
	input  bmhq_pkg::ram_req_t req,
	output bmhq_pkg::entry_t   rdata_a,
	output bmhq_pkg::entry_t   rdata_b
);

	bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

// ===== hw/rtl/binary_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Min-heap priority queue of entity ids held in a slot memory.
// ----------------------------------------------------------------------------
// Usage: drive op, entity_id and priority_req and raise start; the command
// beat is taken on a clock edge where start is high and busy is low. busy
// stays high while the command runs. The result beat (status, min_entity,
// found, position, occupancy) is shown for exactly one cycle with done high;
// the receiver cannot stall it, so it must take the beat in that cycle.
// Steps of each command, around the registered reads of the slot memory:
//   insert  : S_UP_RD reads the parent, S_UP_CMP moves it down, per level up
//   extract : S_EX_LOAD takes the root and last entry, then per level walked
//             down S_DN_RD reads both children and S_DN_CMP moves one up
//   find    : one slot read per cycle, from slot 1 up to occupancy
//   full insert, empty extract, unused op: answered without leaving idle
// done is registered and rises with busy low; a new command may be accepted
// in that same cycle. Reset empties the heap (count to zero); the slot
// memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [bmhq_pkg::ID_BITS-1:0] entity_id,
	input  logic [bmhq_pkg::PRI_BITS-1:0] priority_req,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [bmhq_pkg::ID_BITS-1:0] min_entity,
	output logic                         found,
	output logic [bmhq_pkg::CNT_BITS-1:0] position,
	output logic [bmhq_pkg::CNT_BITS-1:0] occupancy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_EX_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_FIND
	} state_t;

	localparam bmhq_pkg::slot_t SLOT_ONE = bmhq_pkg::slot_t'(1);
	localparam bmhq_pkg::slot_t SLOT_CAP = bmhq_pkg::slot_t'(bmhq_pkg::CAPACITY);

	state_t                state_q;
	bmhq_pkg::slot_t       count_q;
	bmhq_pkg::slot_t       s_q;
	bmhq_pkg::entry_t      cur_q;
	logic [bmhq_pkg::ID_BITS-1:0] min_q;
	bmhq_pkg::slot_t       fs_q;
	bmhq_pkg::slot_t       pos_s1;
	logic                  pend_s1;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [bmhq_pkg::ID_BITS-1:0] min_entity_q;
	logic                  found_q;
	bmhq_pkg::slot_t       position_q;
	bmhq_pkg::slot_t       occupancy_q;

	bmhq_pkg::ram_req_t    req;
	bmhq_pkg::entry_t      rd_a;
	bmhq_pkg::entry_t      rd_b;

	logic                  accept;
	logic [bmhq_pkg::CNT_BITS:0] l_w;
	logic [bmhq_pkg::CNT_BITS:0] r_w;
	logic [bmhq_pkg::CNT_BITS:0] cnt_w;
	logic                  l_ok;
	logic                  r_ok;
	logic                  up_less;
	logic                  take_l;
	logic                  take_r;
	logic [bmhq_pkg::PRI_BITS-1:0] best_pri;
	logic                  fd_hit;
	logic                  fd_more;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign l_w   = {s_q, 1'b0};
	assign r_w   = {s_q, 1'b1};
	assign cnt_w = {1'b0, count_q};
	assign l_ok  = (l_w <= cnt_w);
	assign r_ok  = (r_w <= cnt_w);

	assign up_less  = cur_q.pri < rd_a.pri;
	assign take_l   = rd_a.pri < cur_q.pri;
	assign best_pri = take_l ? rd_a.pri : cur_q.pri;
	assign take_r   = r_ok && (rd_b.pri < best_pri);

	assign fd_hit  = pend_s1 && (rd_a.id == min_q);
	assign fd_more = (fs_q <= count_q);

	bmhq_ram u_ram (
		.clk     (clk),
		.req     (req),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				// root and last slot for an extract
				req.raddr_a = bmhq_pkg::slot_to_addr(SLOT_ONE);
				req.raddr_b = bmhq_pkg::slot_to_addr(count_q);
			end
			S_UP_RD: begin
				if (s_q == SLOT_ONE) begin
					req.we    = 1'b1;
					req.waddr = bmhq_pkg::slot_to_addr(s_q);
					req.wdata = cur_q;
				end else begin
					req.raddr_a = bmhq_pkg::slot_to_addr(s_q >> 1);
				end
			end
			S_UP_CMP: begin
				// move the parent down, or drop the new entry in place
				req.we    = 1'b1;
				req.waddr = bmhq_pkg::slot_to_addr(s_q);
				req.wdata = up_less ? rd_a : cur_q;
			end
			S_DN_RD: begin
				if (!l_ok) begin
					req.we    = 1'b1;
					req.waddr = bmhq_pkg::slot_to_addr(s_q);
					req.wdata = cur_q;
				end else begin
					req.raddr_a = bmhq_pkg::addr_t'(l_w - 1'b1);
					req.raddr_b = bmhq_pkg::addr_t'(r_w - 1'b1);
				end
			end
			S_DN_CMP: begin
				req.we    = 1'b1;
				req.waddr = bmhq_pkg::slot_to_addr(s_q);
				if (take_r) begin
					req.wdata = rd_b;
				end else if (take_l) begin
					req.wdata = rd_a;
				end else begin
					req.wdata = cur_q;
				end
			end
			S_FIND: begin
				req.raddr_a = bmhq_pkg::slot_to_addr(fs_q);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			s_q          <= '0;
			cur_q        <= '0;
			min_q        <= '0;
			fs_q         <= '0;
			pos_s1       <= '0;
			pend_s1      <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= bmhq_pkg::ST_OK;
			min_entity_q <= '0;
			found_q      <= 1'b0;
			position_q   <= '0;
			occupancy_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q     <= bmhq_pkg::ST_OK;
						min_entity_q <= '0;
						found_q      <= 1'b0;
						position_q   <= '0;
						occupancy_q  <= count_q;
						case (bmhq_pkg::op_t'(op))
							bmhq_pkg::OP_INSERT: begin
								if (count_q == SLOT_CAP) begin
									status_q <= bmhq_pkg::ST_FULL;
									done_q   <= 1'b1;
								end else begin
									count_q <= count_q + SLOT_ONE;
									s_q     <= count_q + SLOT_ONE;
									cur_q   <= '{id: entity_id, pri: priority_req};
									state_q <= S_UP_RD;
								end
							end
							bmhq_pkg::OP_EXTRACT: begin
								if (count_q == '0) begin
									status_q <= bmhq_pkg::ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_EX_LOAD;
								end
							end
							bmhq_pkg::OP_FIND: begin
								min_q   <= entity_id;
								fs_q    <= SLOT_ONE;
								pend_s1 <= 1'b0;
								state_q <= S_FIND;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_UP_RD: begin
					if (s_q == SLOT_ONE) begin
						occupancy_q <= count_q;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_less) begin
						s_q     <= s_q >> 1;
						state_q <= S_UP_RD;
					end else begin
						occupancy_q <= count_q;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_EX_LOAD: begin
					// last entry travels down from the root
					min_entity_q <= rd_a.id;
					cur_q        <= rd_b;
					count_q      <= count_q - SLOT_ONE;
					s_q          <= SLOT_ONE;
					state_q      <= S_DN_RD;
				end
				S_DN_RD: begin
					if (!l_ok) begin
						occupancy_q <= count_q;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (take_r) begin
						s_q     <= bmhq_pkg::slot_t'(r_w);
						state_q <= S_DN_RD;
					end else if (take_l) begin
						s_q     <= bmhq_pkg::slot_t'(l_w);
						state_q <= S_DN_RD;
					end else begin
						occupancy_q <= count_q;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_FIND: begin
					if (fd_hit) begin
						found_q    <= 1'b1;
						position_q <= pos_s1;
						done_q     <= 1'b1;
						pend_s1    <= 1'b0;
						state_q    <= S_IDLE;
					end else if (fd_more) begin
						// advance the scan, one slot read per cycle
						pos_s1  <= fs_q;
						pend_s1 <= 1'b1;
						fs_q    <= fs_q + SLOT_ONE;
					end else begin
						done_q  <= 1'b1;
						pend_s1 <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign min_entity = min_entity_q;
	assign found      = found_q;
	assign position   = position_q;
	assign occupancy  = occupancy_q;

endmodule

// ===== tb/sv/binary_min_heap_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb
// Checks the min-heap queue against a behavioral heap kept in the bench.
// Commands go in through the start/busy handshake. Each done beat is compared,
// field by field, with the oldest predicted reply. Test phases: directed edge
// cases, fill to capacity and drain to half, random command mix on the deep
// heap, and back-to-back commands with no idle gaps.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 40;

	typedef logic [bmhq_pkg::ID_BITS-1:0]  id_t;
	typedef logic [bmhq_pkg::PRI_BITS-1:0] pri_t;

	typedef struct {
		bmhq_pkg::status_t status;
		id_t               min_entity;
		logic              found;
		bmhq_pkg::slot_t   position;
		bmhq_pkg::slot_t   occupancy;
	} heap_reply_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [1:0]      op;
	id_t             entity_id;
	pri_t            priority_req;
	logic            done;
	logic [1:0]      status;
	id_t             min_entity;
	logic            found;
	bmhq_pkg::slot_t position;
	bmhq_pkg::slot_t occupancy;

	// behavioral heap, one-based
	id_t             heap_id [1:bmhq_pkg::CAPACITY];
	pri_t            heap_pri [1:bmhq_pkg::CAPACITY];
	int              heap_count;

	heap_reply_t replies_due[$];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          idle_enable;

	binary_min_heap_queue_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.entity_id    (entity_id),
		.priority_req (priority_req),
		.done         (done),
		.status       (status),
		.min_entity   (min_entity),
		.found        (found),
		.position     (position),
		.occupancy    (occupancy)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// apply one command to the behavioral heap and work out its reply
	task automatic predict_heap_op(input bmhq_pkg::op_t cmd, input id_t id,
			input pri_t pri, output heap_reply_t r);
		int s;
		int best;
		id_t  tid;
		pri_t tpri;
		r.status     = bmhq_pkg::ST_OK;
		r.min_entity = '0;
		r.found      = 1'b0;
		r.position   = '0;
		case (cmd)
			bmhq_pkg::OP_INSERT: begin
				if (heap_count >= bmhq_pkg::CAPACITY) begin
					r.status = bmhq_pkg::ST_FULL;
				end else begin
					heap_count++;
					s = heap_count;
					while (s > 1 && pri < heap_pri[s / 2]) begin
						heap_id[s]  = heap_id[s / 2];
						heap_pri[s] = heap_pri[s / 2];
						s = s / 2;
					end
					heap_id[s]  = id;
					heap_pri[s] = pri;
				end
			end
			bmhq_pkg::OP_EXTRACT: begin
				if (heap_count == 0) begin
					r.status = bmhq_pkg::ST_EMPTY;
				end else begin
					r.min_entity = heap_id[1];
					heap_id[1]   = heap_id[heap_count];
					heap_pri[1]  = heap_pri[heap_count];
					heap_count--;
					s = 1;
					forever begin
						best = s;
						// left child wins ties: right must be strictly smaller
						if (2 * s <= heap_count && heap_pri[2 * s] < heap_pri[best])
							best = 2 * s;
						if (2 * s + 1 <= heap_count && heap_pri[2 * s + 1] < heap_pri[best])
							best = 2 * s + 1;
						if (best == s)
							break;
						tid            = heap_id[s];
						tpri           = heap_pri[s];
						heap_id[s]     = heap_id[best];
						heap_pri[s]    = heap_pri[best];
						heap_id[best]  = tid;
						heap_pri[best] = tpri;
						s = best;
					end
				end
			end
			bmhq_pkg::OP_FIND: begin
				for (s = 1; s <= heap_count; s++) begin
					if (heap_id[s] == id) begin
						r.found    = 1'b1;
						r.position = bmhq_pkg::slot_t'(s);
						break;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = bmhq_pkg::slot_t'(heap_count);
	endtask

	// send one command beat, with an optional idle burst ahead of it
	task automatic issue_command(input bmhq_pkg::op_t cmd, input id_t id, input pri_t pri);
		heap_reply_t exp_reply;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start        <= 1'b1;
		op           <= cmd;
		entity_id    <= id;
		priority_req <= pri;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_heap_op(cmd, id, pri, exp_reply);
		replies_due.push_back(exp_reply);
	endtask

	// compare each done beat with the oldest predicted reply
	always @(posedge clk) begin
		heap_reply_t e;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("done beat with no reply pending");
				err_count++;
			end else begin
				e = replies_due.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					err_count++;
				end
				if (min_entity !== e.min_entity) begin
					$error("min_entity: expected %0h, actual %0h", e.min_entity, min_entity);
					err_count++;
				end
				if (found !== e.found) begin
					$error("found: expected %0d, actual %0d", e.found, found);
					err_count++;
				end
				if (position !== e.position) begin
					$error("position: expected %0d, actual %0d", e.position, position);
					err_count++;
				end
				if (occupancy !== e.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", e.occupancy, occupancy);
					err_count++;
				end
			end
		end
	end

	// mix of wide ids and a few small ones, so duplicates show up
	function automatic id_t pick_id();
		if ($urandom_range(0, 1) == 0)
			return id_t'($urandom_range(0, 7));
		return id_t'($urandom);
	endfunction

	// narrow range in three of eight draws, plus all-zero and all-one values, to force priority ties
	function automatic pri_t pick_pri();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return pri_t'($urandom_range(0, 15));
			default: return pri_t'($urandom);
		endcase
	endfunction

	// half the time an id that is in the heap, else a random one
	function automatic id_t pick_find_id();
		if (heap_count > 0 && $urandom_range(0, 1) == 0)
			return heap_id[$urandom_range(1, heap_count)];
		return pick_id();
	endfunction

	task automatic test_directed_edges();
		issue_command(bmhq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_FIND, 16'h1234, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		issue_command(bmhq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		issue_command(bmhq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_INSERT, 16'h0005, 32'd100);
		issue_command(bmhq_pkg::OP_INSERT, 16'h0005, 32'd100);
		issue_command(bmhq_pkg::OP_INSERT, 16'h0009, 32'd100);
		issue_command(bmhq_pkg::OP_INSERT, 16'hAAAA, 32'd50);
		issue_command(bmhq_pkg::OP_FIND, 16'h0005, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_FIND, 16'hFFFF, 32'hFFFF_FFFF);
		issue_command(bmhq_pkg::OP_FIND, 16'h0000, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_FIND, 16'h0001, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_NOP, 16'h5555, 32'h5555_5555);
		repeat (6) issue_command(bmhq_pkg::OP_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);
		issue_command(bmhq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
		// equal priority must not sift up past the parent
		issue_command(bmhq_pkg::OP_INSERT, 16'h0007, 32'd7);
		issue_command(bmhq_pkg::OP_INSERT, 16'h0008, 32'd7);
		issue_command(bmhq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
	endtask

	task automatic test_fill_and_drain();
		while (heap_count < bmhq_pkg::CAPACITY)
			issue_command(bmhq_pkg::OP_INSERT, pick_id(), pick_pri());
		issue_command(bmhq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000);
		issue_command(bmhq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		issue_command(bmhq_pkg::OP_INSERT, pick_id(), pick_pri());
		issue_command(bmhq_pkg::OP_FIND, heap_id[bmhq_pkg::CAPACITY], 32'h0000_0000);
		issue_command(bmhq_pkg::OP_FIND, heap_id[1], 32'h0000_0000);
		repeat (6) issue_command(bmhq_pkg::OP_FIND, pick_find_id(), pri_t'($urandom));
		issue_command(bmhq_pkg::OP_NOP, pick_id(), pri_t'($urandom));
		// leave a deep heap behind for the random phases
		while (heap_count > bmhq_pkg::CAPACITY / 2)
			issue_command(bmhq_pkg::OP_EXTRACT, pick_id(), pri_t'($urandom));
	endtask

	task automatic run_random_mix(input int n_cmds);
		int sel;
		repeat (n_cmds) begin
			sel = $urandom_range(0, 19);
			if (sel < 9)
				issue_command(bmhq_pkg::OP_INSERT, pick_id(), pick_pri());
			else if (sel < 15)
				issue_command(bmhq_pkg::OP_EXTRACT, pick_id(), pri_t'($urandom));
			else if (sel < 19)
				issue_command(bmhq_pkg::OP_FIND, pick_find_id(), pri_t'($urandom));
			else
				issue_command(bmhq_pkg::OP_NOP, pick_id(), pri_t'($urandom));
		end
	endtask

	task automatic test_random_mix();
		run_random_mix(50);
	endtask

	task automatic test_back_to_back();
		idle_enable = 1'b0;
		run_random_mix(30);
	endtask

	initial begin
		heap_count   = 0;
		idle_enable  = 1'b1;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		op           <= bmhq_pkg::OP_NOP;
		entity_id    <= '0;
		priority_req <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_fill_and_drain();
		test_random_mix();
		test_back_to_back();

		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		// hold a while longer to catch stray done beats
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/binary_min_heap_queue_top.sv
tb/sv/binary_min_heap_queue_top_tb.sv
